// ----- rtl/core/box_downsample_palette_match_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the box downsample palette match unit
// Helpers for the concurrent checks at the end of the top RTL module.
// ----------------------------------------------------------------------------
`ifndef BOX_DOWNSAMPLE_PALETTE_MATCH_UNIT_ASSERT_SVH
`define BOX_DOWNSAMPLE_PALETTE_MATCH_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BDPM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bdpm: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BDPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bdpm: next-cycle check failed");

`endif

// ----- rtl/core/bdpm_pkg.sv -----
// ----------------------------------------------------------------------------
// Box downsample palette match package
// Field layout, codes and shared types of the palette match unit.
// ----------------------------------------------------------------------------
package bdpm_pkg;

   localparam int CHAN_W       = 16;
   localparam int CODE_FIELD_W = 32;
   localparam int INDEX_W      = 8;
   localparam int UNKNOWN_W    = 3;
   localparam int SUM_W        = 18;
   localparam int FIT_W        = 34;
   localparam int BLOCK_PIXELS = 4;
   localparam int AVG_SHIFT    = 2;
   localparam int WIDE_W       = 14;

   // request tdata layout, lowest bit first
   localparam int REQ_INDEX_LSB = 0;
   localparam int REQ_CODE_LSB  = 8;
   localparam int REQ_RED_LSB   = 40;
   localparam int REQ_GREEN_LSB = 56;
   localparam int REQ_BLUE_LSB  = 72;
   localparam int REQ_PIX_LSB   = 88;
   localparam int REQ_DATA_W    = 216;

   localparam int RSP_DATA_W    = 48;

   localparam int CSR_ADDR_W    = 1;
   localparam int CSR_DATA_W    = 9;

   localparam logic [CSR_ADDR_W-1:0] CSR_USE_AVERAGING = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PALETTE_COUNT = 1'b1;

   localparam logic CMD_WRITE_ENTRY = 1'b0;
   localparam logic CMD_BLOCK       = 1'b1;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } color_type;

   // palette entry moving along the match chain or into the distance unit
   typedef struct packed {
      logic      valid;
      color_type color;
   } link_type;

endpackage

// ----- rtl/core/box_downsample_palette_match_unit.sv -----
// ----------------------------------------------------------------------------
// Box downsample palette match unit
// Reduces a 2x2 block of indexed pixels to one pixel, either by taking the
// top-left code or by averaging the palette colors and matching the nearest.
// ----------------------------------------------------------------------------
//
//   channel  direction  tdata / tuser                       transfer when
//   req_     in         palette entry or 2x2 block / cmd    req_tvalid & req_tready
//   rsp_     out        destination pixel / empty flag      rsp_tvalid & rsp_tready
//   csr_     in         register index and data             csr_we
//
// A palette write and a block with averaging off do not read the palette.
// A block with averaging on and N > 0 active entries walks them twice: the
// palette memory's single read port is walked once through the four-cell
// code match chain and once through the distance pipe.
// The result waits in an output register, so the next item is taken meanwhile.
// Reset is synchronous; the palette is undefined after reset until written.
// ----------------------------------------------------------------------------
module box_downsample_palette_match_unit #(
   parameter int PALETTE_SIZE = 256,
   parameter int PIXEL_BITS   = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_we,
   input  logic [bdpm_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [bdpm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   // requests
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // entry_index, entry_code, entry_red, entry_green, entry_blue,
   // pixel_top_left, pixel_top_right, pixel_bottom_left, pixel_bottom_right
   input  logic [bdpm_pkg::REQ_DATA_W-1:0]      req_tdata,
   // cmd
   input  logic                                 req_tuser,
   // results
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // out_pixel, out_index, unknown_count, zero fill
   output logic [bdpm_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // empty_palette
   output logic                                 rsp_tuser
);

   `include "box_downsample_palette_match_unit_assert.svh"

   localparam int IDX_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
   localparam int CNT_W = $clog2(PALETTE_SIZE + 1);
   localparam int CW    = bdpm_pkg::CHAN_W;
   localparam int MEM_W = PIXEL_BITS + 3 * CW;
   localparam int WW    = bdpm_pkg::WIDE_W;
   localparam int NPIX  = bdpm_pkg::BLOCK_PIXELS;
   localparam int UW    = bdpm_pkg::UNKNOWN_W;

   typedef enum logic [6:0] {
      ST_IDLE        = 7'b0000001,
      ST_MATCH       = 7'b0000010,
      ST_MATCH_WAIT  = 7'b0000100,
      ST_SUM         = 7'b0001000,
      ST_SEARCH      = 7'b0010000,
      ST_SEARCH_WAIT = 7'b0100000,
      ST_FINISH      = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic                            use_avg_ff;
   logic [bdpm_pkg::CSR_DATA_W-1:0] pal_count_ff;
   logic [CNT_W-1:0]                active_count;

   // palette memory
   logic [MEM_W-1:0]  palette_mem [PALETTE_SIZE];
   logic              mem_we;
   logic              mem_re;
   logic [WW-1:0]     slot_wide;
   logic              slot_ok;
   logic [MEM_W-1:0]  mem_wdata;
   logic [MEM_W-1:0]  rd_data_ff;
   logic              rd_match_ff;
   logic              rd_search_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic [PIXEL_BITS-1:0] rd_code;
   bdpm_pkg::color_type   rd_color;

   // walk control
   logic [CNT_W-1:0]  walk_ff, walk_in;
   logic              walk_last;
   logic              req_xfer;
   logic              block_start;

   // match chain
   bdpm_pkg::link_type    chain_link [NPIX+1];
   logic [PIXEL_BITS-1:0] chain_code [NPIX+1];
   logic [NPIX-1:0]       cell_found;
   bdpm_pkg::color_type   cell_color [NPIX];
   logic                  chain_busy;

   // block average
   logic [bdpm_pkg::SUM_W-1:0] sum_r, sum_g, sum_b;
   bdpm_pkg::color_type        avg_ff;
   logic [UW-1:0]              unknown_in;

   // distance unit
   bdpm_pkg::link_type    dist_link;
   logic                  dist_start;
   logic                  dist_busy;
   logic [IDX_W-1:0]      best_idx;
   logic [PIXEL_BITS-1:0] best_code;
   logic [WW-1:0]         best_idx_wide;

   // pending result and output register
   logic [PIXEL_BITS-1:0]        res_pixel_ff;
   logic [bdpm_pkg::INDEX_W-1:0] res_index_ff;
   logic [UW-1:0]                res_unknown_ff;
   logic                         res_empty_ff;
   logic                         rsp_load;
   logic                         rsp_tvalid_ff;
   logic [PIXEL_BITS-1:0]        rsp_pixel_ff;
   logic [bdpm_pkg::INDEX_W-1:0] rsp_index_ff;
   logic [UW-1:0]                rsp_unknown_ff;
   logic                         rsp_empty_ff;
   logic                         empty_out_ok;

   // ------------------------------------------------------------------------
   // configuration
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         use_avg_ff   <= 1'b0;
         pal_count_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            bdpm_pkg::CSR_USE_AVERAGING: begin
               use_avg_ff <= csr_wdata[0];
            end
            bdpm_pkg::CSR_PALETTE_COUNT: begin
               pal_count_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // saturate the entry count to the palette depth
   assign active_count = ((WW'(pal_count_ff)) > WW'(PALETTE_SIZE))
                         ? CNT_W'(PALETTE_SIZE) : CNT_W'(pal_count_ff);

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_xfer    = req_tvalid && req_tready;
   assign block_start = req_xfer && (req_tuser == bdpm_pkg::CMD_BLOCK);

   assign slot_wide = WW'(req_tdata[bdpm_pkg::REQ_INDEX_LSB +: bdpm_pkg::INDEX_W]);
   assign slot_ok   = slot_wide < WW'(PALETTE_SIZE);
   assign mem_we    = req_xfer && (req_tuser == bdpm_pkg::CMD_WRITE_ENTRY) && slot_ok;
   assign mem_wdata = {req_tdata[bdpm_pkg::REQ_CODE_LSB +: PIXEL_BITS],
                       req_tdata[bdpm_pkg::REQ_RED_LSB +: CW],
                       req_tdata[bdpm_pkg::REQ_GREEN_LSB +: CW],
                       req_tdata[bdpm_pkg::REQ_BLUE_LSB +: CW]};

   // ------------------------------------------------------------------------
   // palette memory: one write port, one registered read port
   // ------------------------------------------------------------------------
   assign mem_re = (state_ff == ST_MATCH) || (state_ff == ST_SEARCH);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         palette_mem[slot_wide[IDX_W-1:0]] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= palette_mem[walk_ff[IDX_W-1:0]];
      end
      rd_idx_ff <= walk_ff[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_match_ff  <= 1'b0;
         rd_search_ff <= 1'b0;
      end else begin
         rd_match_ff  <= (state_ff == ST_MATCH);
         rd_search_ff <= (state_ff == ST_SEARCH);
      end
   end

   assign rd_code  = rd_data_ff[MEM_W-1 -: PIXEL_BITS];
   assign rd_color = bdpm_pkg::color_type'(rd_data_ff[3*CW-1:0]);

   // ------------------------------------------------------------------------
   // code match chain
   // ------------------------------------------------------------------------
   assign chain_link[0].valid = rd_match_ff;
   assign chain_link[0].color = rd_color;
   assign chain_code[0]       = rd_code;

   for (genvar k = 0; k < NPIX; k++) begin : g_cell
      bdpm_match_cell #(
         .PIXEL_BITS (PIXEL_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .start     (block_start),
         .load_code (req_tdata[bdpm_pkg::REQ_PIX_LSB + k*bdpm_pkg::CODE_FIELD_W +: PIXEL_BITS]),
         .in_link   (chain_link[k]),
         .in_code   (chain_code[k]),
         .out_link  (chain_link[k+1]),
         .out_code  (chain_code[k+1]),
         .found     (cell_found[k]),
         .color     (cell_color[k])
      );
   end

   always_comb begin
      chain_busy = 1'b0;
      for (int k = 1; k <= NPIX; k++) begin
         chain_busy = chain_busy || chain_link[k].valid;
      end
   end

   // sum the found colors; unknown codes add zero
   always_comb begin
      sum_r = '0;
      sum_g = '0;
      sum_b = '0;
      for (int k = 0; k < NPIX; k++) begin
         if (cell_found[k]) begin
            sum_r = sum_r + bdpm_pkg::SUM_W'(cell_color[k].red);
            sum_g = sum_g + bdpm_pkg::SUM_W'(cell_color[k].green);
            sum_b = sum_b + bdpm_pkg::SUM_W'(cell_color[k].blue);
         end
      end
      unknown_in = UW'(NPIX) - UW'($countones(cell_found));
   end

   // ------------------------------------------------------------------------
   // nearest color search
   // ------------------------------------------------------------------------
   assign dist_start      = (state_ff == ST_SUM);
   assign dist_link.valid = rd_search_ff;
   assign dist_link.color = rd_color;

   bdpm_dist_unit #(
      .PIXEL_BITS (PIXEL_BITS),
      .IDX_W      (IDX_W)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .start     (dist_start),
      .in_link   (dist_link),
      .in_idx    (rd_idx_ff),
      .in_code   (rd_code),
      .avg       (avg_ff),
      .busy      (dist_busy),
      .best_idx  (best_idx),
      .best_code (best_code)
   );

   assign best_idx_wide = WW'(best_idx);

   // ------------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------------
   assign walk_last = ((walk_ff + CNT_W'(1)) == active_count);
   assign rsp_load  = (state_ff == ST_FINISH) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      walk_in  = walk_ff;
      case (state_ff)
         ST_IDLE: begin
            walk_in = '0;
            if (block_start) begin
               if (use_avg_ff && (active_count != '0)) begin
                  state_in = ST_MATCH;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_MATCH: begin
            walk_in = walk_ff + CNT_W'(1);
            if (walk_last) begin
               state_in = ST_MATCH_WAIT;
            end
         end
         ST_MATCH_WAIT: begin
            if (!rd_match_ff && !chain_busy) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            walk_in  = '0;
            state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            walk_in = walk_ff + CNT_W'(1);
            if (walk_last) begin
               state_in = ST_SEARCH_WAIT;
            end
         end
         ST_SEARCH_WAIT: begin
            if (!rd_search_ff && !dist_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         walk_ff  <= '0;
      end else begin
         state_ff <= state_in;
         walk_ff  <= walk_in;
      end
   end

   // pending result
   always_ff @(posedge clock) begin
      if (block_start) begin
         if (!use_avg_ff) begin
            res_pixel_ff   <= req_tdata[bdpm_pkg::REQ_PIX_LSB +: PIXEL_BITS];
            res_index_ff   <= '0;
            res_unknown_ff <= '0;
            res_empty_ff   <= 1'b0;
         end else begin
            // averaging: all codes unknown until ST_SUM, which an empty palette never reaches
            res_pixel_ff   <= '0;
            res_index_ff   <= '0;
            res_unknown_ff <= UW'(NPIX);
            res_empty_ff   <= (active_count == '0);
         end
      end
      if (state_ff == ST_SUM) begin
         avg_ff.red     <= CW'(sum_r >> bdpm_pkg::AVG_SHIFT);
         avg_ff.green   <= CW'(sum_g >> bdpm_pkg::AVG_SHIFT);
         avg_ff.blue    <= CW'(sum_b >> bdpm_pkg::AVG_SHIFT);
         res_unknown_ff <= unknown_in;
      end
      if ((state_ff == ST_SEARCH_WAIT) && (state_in == ST_FINISH)) begin
         res_pixel_ff <= best_code;
         res_index_ff <= best_idx_wide[bdpm_pkg::INDEX_W-1:0];
      end
   end

   // ------------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_pixel_ff   <= res_pixel_ff;
         rsp_index_ff   <= res_index_ff;
         rsp_unknown_ff <= res_unknown_ff;
         rsp_empty_ff   <= res_empty_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {(bdpm_pkg::RSP_DATA_W - bdpm_pkg::CODE_FIELD_W
                         - bdpm_pkg::INDEX_W - UW)'(0),
                        rsp_unknown_ff,
                        rsp_index_ff,
                        bdpm_pkg::CODE_FIELD_W'(rsp_pixel_ff)};
   assign rsp_tuser  = rsp_empty_ff;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   assign empty_out_ok = rsp_tvalid_ff && (rsp_pixel_ff == '0)
                         && (rsp_unknown_ff == UW'(NPIX));

   `BDPM_ASSERT_NOW(a_no_read_during_write, clock, reset, mem_we, !mem_re)
   `BDPM_ASSERT_NOW(a_chain_drained, clock, reset, dist_start, !rd_match_ff && !chain_busy)
   `BDPM_ASSERT_NOW(a_walk_in_range, clock, reset, mem_re, walk_ff < active_count)
   `BDPM_ASSERT_NEXT(a_empty_result, clock, reset, rsp_load && res_empty_ff, empty_out_ok)

endmodule

// ----- rtl/core/bdpm_match_cell.sv -----
// ----------------------------------------------------------------------------
// Palette match cell
// Holds one block code, catches the color of the first palette entry that
// carries it and hands each entry on to the next cell.
// ----------------------------------------------------------------------------
module bdpm_match_cell #(
   parameter int PIXEL_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [PIXEL_BITS-1:0]      load_code,
   input  bdpm_pkg::link_type         in_link,
   input  logic [PIXEL_BITS-1:0]      in_code,
   output bdpm_pkg::link_type         out_link,
   output logic [PIXEL_BITS-1:0]      out_code,
   output logic                       found,
   output bdpm_pkg::color_type        color
);

   logic                  valid_ff;
   bdpm_pkg::color_type   pass_color_ff;
   logic [PIXEL_BITS-1:0] pass_code_ff;
   logic [PIXEL_BITS-1:0] code_ff;
   logic                  found_ff;
   logic                  found_in;
   logic                  hit;
   bdpm_pkg::color_type   color_ff;

   // only the first hit counts: entries arrive in index order
   assign hit      = in_link.valid && !found_ff && (in_code == code_ff);
   assign found_in = start ? 1'b0 : (found_ff || hit);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         found_ff <= 1'b0;
      end else begin
         valid_ff <= in_link.valid;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      pass_color_ff <= in_link.color;
      pass_code_ff  <= in_code;
      if (start) begin
         code_ff <= load_code;
      end
      if (hit) begin
         color_ff <= in_link.color;
      end
   end

   assign out_link.valid = valid_ff;
   assign out_link.color = pass_color_ff;
   assign out_code       = pass_code_ff;
   assign found          = found_ff;
   assign color          = color_ff;

endmodule

// ----- rtl/core/bdpm_dist_unit.sv -----
// ----------------------------------------------------------------------------
// Nearest color distance unit
// Pipelined squared RGB distance of each streamed palette entry to the
// block average, keeping the first entry with the least distance.
// ----------------------------------------------------------------------------
module bdpm_dist_unit #(
   parameter int PIXEL_BITS = 32,
   parameter int IDX_W      = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  bdpm_pkg::link_type    in_link,
   input  logic [IDX_W-1:0]      in_idx,
   input  logic [PIXEL_BITS-1:0] in_code,
   input  bdpm_pkg::color_type   avg,
   output logic                  busy,
   output logic [IDX_W-1:0]      best_idx,
   output logic [PIXEL_BITS-1:0] best_code
);

   localparam int CW = bdpm_pkg::CHAN_W;
   localparam int SW = 2 * bdpm_pkg::CHAN_W;
   localparam int FW = bdpm_pkg::FIT_W;

   // stage 1: absolute differences
   logic                  v1_ff;
   logic [IDX_W-1:0]      idx1_ff;
   logic [PIXEL_BITS-1:0] code1_ff;
   logic [CW-1:0]         dr1_ff, dg1_ff, db1_ff;
   logic [CW-1:0]         dr_in, dg_in, db_in;
   // stage 2: squares
   logic                  v2_ff;
   logic [IDX_W-1:0]      idx2_ff;
   logic [PIXEL_BITS-1:0] code2_ff;
   logic [SW-1:0]         sr2_ff, sg2_ff, sb2_ff;
   // stage 3: fit
   logic                  v3_ff;
   logic [IDX_W-1:0]      idx3_ff;
   logic [PIXEL_BITS-1:0] code3_ff;
   logic [FW-1:0]         fit3_ff;
   // best tracker
   logic                  first_ff;
   logic                  take;
   logic [FW-1:0]         best_fit_ff;
   logic [IDX_W-1:0]      best_idx_ff;
   logic [PIXEL_BITS-1:0] best_code_ff;

   always_comb begin
      dr_in = (in_link.color.red > avg.red) ? in_link.color.red - avg.red
                                            : avg.red - in_link.color.red;
      dg_in = (in_link.color.green > avg.green) ? in_link.color.green - avg.green
                                                : avg.green - in_link.color.green;
      db_in = (in_link.color.blue > avg.blue) ? in_link.color.blue - avg.blue
                                              : avg.blue - in_link.color.blue;
   end

   assign take = v3_ff && (first_ff || (fit3_ff < best_fit_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         first_ff <= 1'b1;
      end else begin
         v1_ff <= in_link.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         if (start) begin
            first_ff <= 1'b1;
         end else if (v3_ff) begin
            first_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff  <= in_idx;
      code1_ff <= in_code;
      dr1_ff   <= dr_in;
      dg1_ff   <= dg_in;
      db1_ff   <= db_in;

      idx2_ff  <= idx1_ff;
      code2_ff <= code1_ff;
      sr2_ff   <= SW'(dr1_ff) * SW'(dr1_ff);
      sg2_ff   <= SW'(dg1_ff) * SW'(dg1_ff);
      sb2_ff   <= SW'(db1_ff) * SW'(db1_ff);

      idx3_ff  <= idx2_ff;
      code3_ff <= code2_ff;
      fit3_ff  <= FW'(sr2_ff) + FW'(sg2_ff) + FW'(sb2_ff);

      if (take) begin
         best_fit_ff  <= fit3_ff;
         best_idx_ff  <= idx3_ff;
         best_code_ff <= code3_ff;
      end
   end

   assign busy      = v1_ff || v2_ff || v3_ff;
   assign best_idx  = best_idx_ff;
   assign best_code = best_code_ff;

endmodule
